### sv/nrsf_pkg.sv
`default_nettype none
package nrsf_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int SQUARE_W   = 2 * SAMPLE_W;
   localparam int SUM_W      = 64;
   localparam int RESULT_W   = 64;
   localparam int MULT_W     = 27;
   localparam int PART_W     = 32 + MULT_W;
   localparam int PROD_W     = 90;
   localparam int QUOT_W     = 2 * RESULT_W;
   localparam int SREM_W     = RESULT_W + 3;
   localparam int DIV_STEPS  = PROD_W + RESULT_W;
   localparam int ROOT_STEPS = RESULT_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int GUARD_SHIFT = 16;

   localparam logic [MULT_W-1:0]   SCALE_MULT = 27'd100000000;
   localparam logic [9:0]          GUARD_MULT = 10'd1000;
   localparam logic [RESULT_W-1:0] ONE_Q32    = 64'h0000_0001_0000_0000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] model_sample;
      logic signed [SAMPLE_W-1:0] grad_sample;
      logic                       last_item;
   } req_word_type;

   typedef struct packed {
      logic [RESULT_W-1:0] scale_factor;
      logic                gradient_zero;
      logic                saturated;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GUARD,
      ST_DENOM,
      ST_MULHI,
      ST_SUM,
      ST_CHECK,
      ST_DIV,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_GUARD,
      OP_DENOM,
      OP_MULHI,
      OP_SUM,
      OP_CHECK,
      OP_DIV,
      OP_ROOT,
      OP_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      accept;
   } dp_cmd_type;

   typedef struct packed {
      logic grad_zero;
      logic saturated;
   } dp_status_type;

endpackage
`default_nettype wire

### sv/nrsf_dp.sv
`default_nettype none
module nrsf_dp #(
   parameter int MAX_POINTS = 65536
) (
   input  wire                          clock,
   input  wire                          reset,
   input  nrsf_pkg::dp_cmd_type         cmd,
   input  nrsf_pkg::req_word_type       req_word,
   output nrsf_pkg::dp_status_type      status,
   output nrsf_pkg::rsp_word_type       rsp_word
);

   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int GUARD_W = CNT_W + 10;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   function automatic logic [nrsf_pkg::SAMPLE_W-1:0] magnitude(
      input logic [nrsf_pkg::SAMPLE_W-1:0] v);
      return v[nrsf_pkg::SAMPLE_W-1] ? (~v + 1'b1) : v;
   endfunction

   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [nrsf_pkg::SUM_W-1:0]       msum_ff, msum_in, gsum_ff, gsum_in;
   logic                             add_ff, add_in;
   logic [nrsf_pkg::SQUARE_W-1:0]    msq_ff, msq_in, gsq_ff, gsq_in;
   logic [nrsf_pkg::SAMPLE_W-1:0]    mmag, gmag;
   logic [GUARD_W-1:0]               guard_ff, guard_in;
   logic [nrsf_pkg::SUM_W-1:0]       guard_full;
   logic [nrsf_pkg::SUM_W-1:0]       denom_ff, denom_in;
   logic [nrsf_pkg::PART_W-1:0]      plo_ff, plo_in, phi_ff, phi_in;
   logic [nrsf_pkg::PROD_W-1:0]      prod_ff, prod_in, num_ff, num_in;
   logic [nrsf_pkg::SUM_W-1:0]       rem_ff, rem_in;
   logic [nrsf_pkg::SUM_W:0]         div_trial;
   logic [nrsf_pkg::SUM_W:0]         div_diff;
   logic [nrsf_pkg::QUOT_W-1:0]      quot_ff, quot_in;
   logic [nrsf_pkg::SREM_W-1:0]      srem_ff, srem_in, root_next, root_trial;
   logic [nrsf_pkg::RESULT_W-1:0]    root_ff, root_in;
   logic                             gz_ff, gz_in, sat_ff, sat_in;
   logic                             grad_zero_now, sat_now;

   assign mmag = magnitude(req_word.model_sample);
   assign gmag = magnitude(req_word.grad_sample);
   assign guard_full = nrsf_pkg::SUM_W'({guard_ff, {nrsf_pkg::GUARD_SHIFT{1'b0}}});

   assign grad_zero_now = (gsum_ff == '0);
   assign sat_now = (nrsf_pkg::SUM_W'(prod_ff[nrsf_pkg::PROD_W-1:nrsf_pkg::RESULT_W])
                     >= denom_ff);
   assign status = '{grad_zero: grad_zero_now, saturated: sat_now};

   assign div_trial  = {rem_ff, num_ff[nrsf_pkg::PROD_W-1]};
   assign div_diff   = div_trial - {1'b0, denom_ff};
   assign root_next  = {srem_ff[nrsf_pkg::SREM_W-3:0],
                        quot_ff[nrsf_pkg::QUOT_W-1:nrsf_pkg::QUOT_W-2]};
   assign root_trial = nrsf_pkg::SREM_W'({root_ff, 2'b01});

   always_comb begin
      count_in = count_ff;
      msum_in  = msum_ff;
      gsum_in  = gsum_ff;
      add_in   = 1'b0;
      msq_in   = mmag * mmag;
      gsq_in   = gmag * gmag;
      guard_in = guard_ff;
      denom_in = denom_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      gz_in    = gz_ff;
      sat_in   = sat_ff;
      if (add_ff) begin
         msum_in = msum_ff + nrsf_pkg::SUM_W'(msq_ff);
         gsum_in = gsum_ff + nrsf_pkg::SUM_W'(gsq_ff);
      end
      unique case (cmd.op)
         nrsf_pkg::OP_IDLE: begin
            if (cmd.accept && (count_ff < CNT_MAX)) begin
               count_in = count_ff + 1'b1;
               add_in   = 1'b1;
            end
         end
         nrsf_pkg::OP_GUARD: begin
            guard_in = GUARD_W'(count_ff) * GUARD_W'(nrsf_pkg::GUARD_MULT);
         end
         nrsf_pkg::OP_DENOM: begin
            priority if (msum_ff > guard_full) begin
               denom_in = msum_ff;
            end else if (guard_full == '0) begin
               denom_in = nrsf_pkg::SUM_W'(1);
            end else begin
               denom_in = guard_full;
            end
            plo_in = nrsf_pkg::PART_W'(gsum_ff[31:0]) *
                     nrsf_pkg::PART_W'(nrsf_pkg::SCALE_MULT);
         end
         nrsf_pkg::OP_MULHI: begin
            phi_in = nrsf_pkg::PART_W'(gsum_ff[63:32]) *
                     nrsf_pkg::PART_W'(nrsf_pkg::SCALE_MULT);
         end
         nrsf_pkg::OP_SUM: begin
            prod_in = nrsf_pkg::PROD_W'(plo_ff) + (nrsf_pkg::PROD_W'(phi_ff) << 32);
         end
         nrsf_pkg::OP_CHECK: begin
            gz_in   = grad_zero_now;
            sat_in  = sat_now;
            num_in  = prod_ff;
            rem_in  = '0;
            quot_in = '0;
            srem_in = '0;
            root_in = '0;
         end
         nrsf_pkg::OP_DIV: begin
            num_in = {num_ff[nrsf_pkg::PROD_W-2:0], 1'b0};
            if (div_trial >= {1'b0, denom_ff}) begin
               rem_in  = div_diff[nrsf_pkg::SUM_W-1:0];
               quot_in = {quot_ff[nrsf_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               rem_in  = div_trial[nrsf_pkg::SUM_W-1:0];
               quot_in = {quot_ff[nrsf_pkg::QUOT_W-2:0], 1'b0};
            end
         end
         nrsf_pkg::OP_ROOT: begin
            quot_in = {quot_ff[nrsf_pkg::QUOT_W-3:0], 2'b00};
            if (root_next >= root_trial) begin
               srem_in = root_next - root_trial;
               root_in = {root_ff[nrsf_pkg::RESULT_W-2:0], 1'b1};
            end else begin
               srem_in = root_next;
               root_in = {root_ff[nrsf_pkg::RESULT_W-2:0], 1'b0};
            end
         end
         nrsf_pkg::OP_DONE: begin
            count_in = '0;
            msum_in  = '0;
            gsum_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         msum_ff  <= '0;
         gsum_ff  <= '0;
         add_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         msum_ff  <= msum_in;
         gsum_ff  <= gsum_in;
         add_ff   <= add_in;
      end
   end

   always_ff @(posedge clock) begin
      msq_ff   <= msq_in;
      gsq_ff   <= gsq_in;
      guard_ff <= guard_in;
      denom_ff <= denom_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      gz_ff    <= gz_in;
      sat_ff   <= sat_in;
   end

   always_comb begin
      rsp_word.gradient_zero = gz_ff;
      rsp_word.saturated     = sat_ff && !gz_ff;
      priority if (gz_ff) begin
         rsp_word.scale_factor = nrsf_pkg::ONE_Q32;
      end else if (sat_ff) begin
         rsp_word.scale_factor = '1;
      end else begin
         rsp_word.scale_factor = root_ff;
      end
   end

endmodule
`default_nettype wire

### sv/nrsf_ctrl.sv
`default_nettype none
module nrsf_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire                          last_item,
   input  nrsf_pkg::dp_status_type      status,
   output logic                         busy,
   output logic                         rsp_strobe,
   output nrsf_pkg::dp_cmd_type         cmd
);

   localparam logic [nrsf_pkg::STEP_W-1:0] DIV_LAST  =
      nrsf_pkg::STEP_W'(nrsf_pkg::DIV_STEPS - 1);
   localparam logic [nrsf_pkg::STEP_W-1:0] ROOT_LAST =
      nrsf_pkg::STEP_W'(nrsf_pkg::ROOT_STEPS - 1);

   nrsf_pkg::state_type             state_ff, state_in;
   logic [nrsf_pkg::STEP_W-1:0]     step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         nrsf_pkg::ST_IDLE: begin
            if (start && last_item) state_in = nrsf_pkg::ST_GUARD;
         end
         nrsf_pkg::ST_GUARD: state_in = nrsf_pkg::ST_DENOM;
         nrsf_pkg::ST_DENOM: state_in = nrsf_pkg::ST_MULHI;
         nrsf_pkg::ST_MULHI: state_in = nrsf_pkg::ST_SUM;
         nrsf_pkg::ST_SUM:   state_in = nrsf_pkg::ST_CHECK;
         nrsf_pkg::ST_CHECK: begin
            step_in = '0;
            if (status.grad_zero || status.saturated) begin
               state_in = nrsf_pkg::ST_DONE;
            end else begin
               state_in = nrsf_pkg::ST_DIV;
            end
         end
         nrsf_pkg::ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = nrsf_pkg::ST_ROOT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         nrsf_pkg::ST_ROOT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) state_in = nrsf_pkg::ST_DONE;
         end
         nrsf_pkg::ST_DONE: state_in = nrsf_pkg::ST_IDLE;
         default: state_in = nrsf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = (state_ff != nrsf_pkg::ST_IDLE);
      rsp_strobe = (state_ff == nrsf_pkg::ST_DONE);
      cmd.accept = (state_ff == nrsf_pkg::ST_IDLE) && start;
      unique case (state_ff)
         nrsf_pkg::ST_IDLE:  cmd.op = nrsf_pkg::OP_IDLE;
         nrsf_pkg::ST_GUARD: cmd.op = nrsf_pkg::OP_GUARD;
         nrsf_pkg::ST_DENOM: cmd.op = nrsf_pkg::OP_DENOM;
         nrsf_pkg::ST_MULHI: cmd.op = nrsf_pkg::OP_MULHI;
         nrsf_pkg::ST_SUM:   cmd.op = nrsf_pkg::OP_SUM;
         nrsf_pkg::ST_CHECK: cmd.op = nrsf_pkg::OP_CHECK;
         nrsf_pkg::ST_DIV:   cmd.op = nrsf_pkg::OP_DIV;
         nrsf_pkg::ST_ROOT:  cmd.op = nrsf_pkg::OP_ROOT;
         nrsf_pkg::ST_DONE:  cmd.op = nrsf_pkg::OP_DONE;
         default:            cmd.op = nrsf_pkg::OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrsf_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

### sv/norm_ratio_scaling_factor.sv
// channel   ports                         direction  handshake
// request   start, busy, req_word         in         taken when start && !busy
// response  rsp_strobe, rsp_word          out        one-cycle strobe, no backpressure
//
// an item without the last mark is accumulated while busy stays low, and the next may follow
// a last item keeps busy high through the setup states GUARD, DENOM, MULHI, SUM and
// CHECK, the restoring divider (one quotient bit per cycle), the square root
// recurrence (one root bit per cycle) and the result state DONE
// with a zero gradient sum or an out-of-range factor CHECK skips the divider and the root
// and goes to DONE; synchronous reset clears the sums, the count and the controller; no clearing pass
`default_nettype none
module norm_ratio_scaling_factor #(
   parameter int MAX_POINTS = 65536
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  nrsf_pkg::req_word_type       req_word,
   output logic                         rsp_strobe,
   output nrsf_pkg::rsp_word_type       rsp_word
);

   nrsf_pkg::dp_cmd_type    cmd;
   nrsf_pkg::dp_status_type status;

   nrsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_item  (req_word.last_item),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   nrsf_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .status   (status),
      .rsp_word (rsp_word)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.gradient_zero && rsp_word.saturated))
      else $error("zero gradient and saturation flagged together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.saturated) |-> (rsp_word.scale_factor == '1))
      else $error("saturated word is not all ones");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.last_item) |=> busy)
      else $error("last word did not start the computation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("response not followed by idle");

endmodule
`default_nettype wire

### tb/sv/tb_norm_ratio_scaling_factor.sv
`default_nettype none
module tb_norm_ratio_scaling_factor;
   timeunit 1ns;
   timeprecision 1ps;

   import nrsf_pkg::*;

   localparam int MAX_PAIRS = 65536;
   localparam int RANDOM_PAIRS = 500;
   localparam int DRAIN_CYCLES = 300;

   class scale_scoreboard;
      logic [63:0]  model_sum;
      logic [63:0]  grad_sum;
      logic [16:0]  pair_count;
      rsp_word_type expected_factors[$];
      int           mismatches;

      function new();
         model_sum = '0;
         grad_sum = '0;
         pair_count = '0;
         mismatches = 0;
      endfunction

      task report(string what);
         if (mismatches < 50) begin
            $display("%0t mismatch: %s", $realtime, what);
         end
         mismatches++;
      endtask

      function int pending();
         return expected_factors.size();
      endfunction

      function logic [63:0] square_mag(logic signed [SAMPLE_W-1:0] s);
         logic [SAMPLE_W-1:0] mag;
         mag = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
         return 64'(mag) * 64'(mag);
      endfunction

      // largest y with y*y*denom <= 1e8 * grad_sum * 2^64
      function rsp_word_type ratio_root();
         rsp_word_type r;
         logic [255:0] guard;
         logic [255:0] denom;
         logic [255:0] bound;
         logic [255:0] y;
         logic [255:0] c;
         r = '0;
         if (grad_sum == 0) begin
            r.scale_factor = ONE_Q32;
            r.gradient_zero = 1'b1;
            return r;
         end
         guard = 256'(pair_count) * 256'd1000 * 256'd65536;
         denom = (256'(model_sum) > guard) ? 256'(model_sum) : guard;
         if (denom == 0) begin
            denom = 256'd1;
         end
         bound = (256'(grad_sum) * 256'd100000000) << 64;
         if ((denom << 128) <= bound) begin
            r.scale_factor = '1;
            r.saturated = 1'b1;
            return r;
         end
         y = '0;
         for (int b = 63; b >= 0; b--) begin
            c = y | (256'd1 << b);
            if (c * c * denom <= bound) begin
               y = c;
            end
         end
         r.scale_factor = y[63:0];
         return r;
      endfunction

      function void note_pair(req_word_type w);
         if (pair_count < MAX_PAIRS) begin
            model_sum += square_mag(w.model_sample);
            grad_sum += square_mag(w.grad_sample);
            pair_count++;
         end
         if (w.last_item) begin
            expected_factors.push_back(ratio_root());
            model_sum = '0;
            grad_sum = '0;
            pair_count = '0;
         end
      endfunction

      task check_factor(rsp_word_type got);
         rsp_word_type want;
         if (expected_factors.size() == 0) begin
            report($sformatf("unexpected word factor=%h", got.scale_factor));
            return;
         end
         want = expected_factors.pop_front();
         if (got.scale_factor !== want.scale_factor) begin
            report($sformatf("scale_factor got %h want %h", got.scale_factor,
                             want.scale_factor));
         end
         if (got.gradient_zero !== want.gradient_zero) begin
            report($sformatf("gradient_zero got %b want %b", got.gradient_zero,
                             want.gradient_zero));
         end
         if (got.saturated !== want.saturated) begin
            report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   scale_scoreboard board;
   int           pairs_sent = 0;
   logic         quiet = 1'b0;

   norm_ratio_scaling_factor #(
      .MAX_POINTS(MAX_PAIRS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         board.check_factor(rsp_word);
      end
   end

   task automatic send_pair(input logic signed [SAMPLE_W-1:0] m,
                            input logic signed [SAMPLE_W-1:0] g,
                            input logic last);
      req_word_type w;
      w.model_sample = m;
      w.grad_sample = g;
      w.last_item = last;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      board.note_pair(w);
      pairs_sent++;
      if (!quiet && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // flavor: 0 zero, 1 small, 2 extremes, otherwise full range
   function automatic logic signed [SAMPLE_W-1:0] draw_sample(int flavor);
      case (flavor)
         0: return '0;
         1: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
         2: begin
            case ($urandom_range(0, 4))
               0: return 24'sh800000;
               1: return 24'sh7fffff;
               2: return -24'sd1;
               3: return 24'sd1;
               default: return '0;
            endcase
         end
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic int draw_flavor();
      int p;
      p = $urandom_range(0, 99);
      if (p < 10) return 0;
      if (p < 35) return 1;
      if (p < 50) return 2;
      return 3;
   endfunction

   initial begin
      int len;
      int mflav;
      int gflav;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single-word vectors at the extremes and near zero
      send_pair('0, '0, 1'b1);
      send_pair(24'sh7fffff, 24'sh800000, 1'b1);
      send_pair(24'sh800000, 24'sh7fffff, 1'b1);
      send_pair(24'sh7fffff, 24'sd1, 1'b1);
      send_pair(24'sd1, 24'sd1, 1'b1);
      send_pair(-24'sd1, -24'sd1, 1'b1);
      send_pair('0, 24'sh800000, 1'b1);
      // small model, guard term dominates
      send_pair('0, 24'sh7fffff, 1'b0);
      send_pair(24'sd3, 24'sh800000, 1'b0);
      send_pair(-24'sd2, 24'sd5, 1'b1);
      // zero gradient with nonzero model
      send_pair(24'sh800000, '0, 1'b0);
      send_pair(24'sh7fffff, '0, 1'b0);
      send_pair(24'sd100, '0, 1'b0);
      send_pair(-24'sd100, '0, 1'b1);
      // large model against tiny gradient
      send_pair(24'sh800000, 24'sd1, 1'b0);
      send_pair(24'sh800000, '0, 1'b1);

      while (pairs_sent < RANDOM_PAIRS + 16) begin
         quiet = (pairs_sent >= 180 && pairs_sent < 330);
         len = ($urandom_range(0, 99) < 5) ? $urandom_range(9, 100) : $urandom_range(1, 8);
         mflav = draw_flavor();
         gflav = draw_flavor();
         for (int i = 0; i < len; i++) begin
            send_pair(draw_sample(mflav), draw_sample(gflav), i == len - 1);
         end
      end

      start <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         board.report("expected word never arrived");
      end
      if (board.mismatches == 0) begin
         $display("** norm_ratio_scaling_factor: PASSED **");
      end else begin
         $display("** norm_ratio_scaling_factor: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("** norm_ratio_scaling_factor: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
sv/nrsf_pkg.sv
sv/nrsf_dp.sv
sv/nrsf_ctrl.sv
sv/norm_ratio_scaling_factor.sv
tb/sv/tb_norm_ratio_scaling_factor.sv
